@@ hw/rtl/tcp_connection_table_engine_unit_macros.svh @@
// assertion macros for the connection table engine checker
`ifndef TCP_CONNECTION_TABLE_ENGINE_UNIT_MACROS_SVH
`define TCP_CONNECTION_TABLE_ENGINE_UNIT_MACROS_SVH
`define TCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");
`define TCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");
`endif

@@ hw/rtl/tce_pkg.sv @@
// shared types, codes and constants of the connection table engine
`default_nettype none
package tce_pkg;
   localparam int TableEntriesDefault = 4;
   localparam int RxBufferBytesDefault = 16384;
   localparam int MaxResults = 64;

   localparam logic [2:0] REQ_SEGMENT = 3'd0;
   localparam logic [2:0] REQ_POLL    = 3'd1;
   localparam logic [2:0] REQ_READ    = 3'd2;
   localparam logic [2:0] REQ_CLOSE   = 3'd3;
   localparam logic [2:0] REQ_WRITE   = 3'd4;

   localparam logic [1:0] CSR_LISTEN_PORT = 2'd0;
   localparam logic [1:0] CSR_INIT_SEQ    = 2'd1;
   localparam logic [1:0] CSR_READ_CHUNK  = 2'd2;
   localparam logic [1:0] CSR_WRITE_SEG   = 2'd3;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_RST = 8'h04;
   localparam logic [7:0] FL_PSH = 8'h08;
   localparam logic [7:0] FL_ACK = 8'h10;

   localparam logic [15:0] LISTEN_PORT_RESET = 16'd80;
   localparam logic [31:0] INIT_SEQ_RESET    = 32'h0001_0000;
   localparam logic [14:0] READ_CHUNK_RESET  = 15'd1024;
   localparam logic [10:0] WRITE_SEG_RESET   = 11'd1200;
   localparam logic [10:0] SEG_MIN = 11'd1024;
   localparam logic [10:0] SEG_MAX = 11'd1460;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EXEC,
      ST_EMIT,
      ST_WAIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_STATUS,
      OP_SEGMENT,
      OP_WRITE
   } op_type;

   typedef struct packed {
      logic load;
      logic search;
      logic exec;
      logic emit;
      logic next_seg;
   } cmd_type;

   typedef struct packed {
      logic more;
   } sts_type;
endpackage
`default_nettype wire

@@ hw/rtl/tce_ctrl.sv @@
// controller state machine of the connection table engine
`default_nettype none
module tce_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire tce_pkg::sts_type sts,
   output tce_pkg::cmd_type     cmd
);
   import tce_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEARCH;
         end
         ST_SEARCH: state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_EMIT;
         ST_EMIT:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (rsp_ready) state_in = sts.more ? ST_EMIT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_SEARCH: cmd.search = 1'b1;
         ST_EXEC:   cmd.exec = 1'b1;
         ST_EMIT:   cmd.emit = 1'b1;
         ST_WAIT: begin
            rsp_valid = 1'b1;
            cmd.next_seg = rsp_ready;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

@@ hw/rtl/tce_datapath.sv @@
// connection table storage and per-word datapath
`default_nettype none
module tce_datapath #(
   parameter int TABLE_ENTRIES = tce_pkg::TableEntriesDefault,
   parameter int RX_BUFFER_BYTES = tce_pkg::RxBufferBytesDefault
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire tce_pkg::cmd_type cmd,
   output tce_pkg::sts_type     sts,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_index,
   input  wire logic [31:0]     csr_wdata,
   input  wire logic [2:0]      req_type,
   input  wire logic [47:0]     req_src_mac,
   input  wire logic [31:0]     req_src_ip,
   input  wire logic [15:0]     req_src_port,
   input  wire logic [15:0]     req_dst_port,
   input  wire logic [31:0]     req_seq_in,
   input  wire logic [7:0]      req_flags_in,
   input  wire logic [15:0]     req_payload_len,
   input  wire logic [2:0]      req_conn_sel,
   input  wire logic [15:0]     req_write_len,
   output logic                 rsp_out_kind,
   output logic [2:0]           rsp_conn_id,
   output logic [31:0]          rsp_peer_ip_out,
   output logic [15:0]          rsp_peer_port_out,
   output logic [47:0]          rsp_peer_mac_out,
   output logic [31:0]          rsp_seq_out,
   output logic [31:0]          rsp_ack_out,
   output logic [7:0]           rsp_flags_out,
   output logic [10:0]          rsp_seg_len,
   output logic [15:0]          rsp_value,
   output logic                 rsp_last
);
   import tce_pkg::*;
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int BW = $clog2(RX_BUFFER_BYTES + 1);
   localparam logic [BW-1:0] RxCap = BW'(RX_BUFFER_BYTES);

   logic [15:0] listen_port_ff;
   logic [31:0] init_seq_ff;
   logic [14:0] read_chunk_ff;
   logic [10:0] write_seg_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [47:0]   mac_ff    [TABLE_ENTRIES];
   logic [31:0]   ip_ff     [TABLE_ENTRIES];
   logic [15:0]   port_ff   [TABLE_ENTRIES];
   logic [31:0]   rnext_ff  [TABLE_ENTRIES];
   logic [31:0]   snext_ff  [TABLE_ENTRIES];
   logic          closed_ff [TABLE_ENTRIES];
   logic [BW-1:0] buf_ff    [TABLE_ENTRIES];
   logic [IW-1:0] cursor_ff;

   logic [2:0]  rtype_ff;
   logic [47:0] rmac_ff;
   logic [31:0] rip_ff, rseq_ff;
   logic [15:0] rsport_ff, rdport_ff, rplen_ff, rwlen_ff;
   logic [7:0]  rfl_ff;
   logic [2:0]  rsel_ff;

   logic          match_ok_ff, free_ok_ff, poll_ok_ff;
   logic [IW-1:0] match_ff, free_ff, poll_ff;

   op_type        op_ff;
   logic [IW-1:0] ent_ff;
   logic [2:0]    sid_ff;
   logic [15:0]   sval_ff;
   logic [7:0]    sfl_ff;
   logic          release_ff;
   logic [15:0]   remain_ff;
   logic [6:0]    nseg_ff;
   logic [10:0]   segmax_ff;

   // table search
   logic          m_ok, f_ok, p_ok;
   logic [IW-1:0] m_i, f_i, p_i, p_t;
   always_comb begin
      int sum;
      m_ok = 1'b0; f_ok = 1'b0; p_ok = 1'b0;
      m_i = '0; f_i = '0; p_i = '0; p_t = '0;
      sum = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!m_ok && valid_ff[i] && port_ff[i] == rsport_ff && ip_ff[i] == rip_ff) begin
            m_ok = 1'b1; m_i = IW'(i);
         end
         if (!f_ok && !valid_ff[i]) begin
            f_ok = 1'b1; f_i = IW'(i);
         end
      end
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         sum = 32'(cursor_ff) + k;
         if (sum >= TABLE_ENTRIES) sum = sum - TABLE_ENTRIES;
         p_t = IW'(sum);
         if (!p_ok && valid_ff[p_t] && buf_ff[p_t] != '0) begin
            p_ok = 1'b1; p_i = p_t;
         end
      end
   end

   logic          sel_ok;
   logic [IW-1:0] sel_i;
   always_comb begin
      sel_ok = (rsel_ff != 3'd0) && (32'(rsel_ff) <= TABLE_ENTRIES);
      sel_i = IW'(rsel_ff - 3'd1);
      if (sel_ok) sel_ok = valid_ff[sel_i];
   end

   logic [BW-1:0] lim, room, take;
   always_comb begin
      lim = (read_chunk_ff == 15'd0) ? BW'(1) : BW'(read_chunk_ff);
      if (32'(read_chunk_ff) > RX_BUFFER_BYTES) lim = RxCap;
      room = RxCap - buf_ff[match_ff];
      take = (BW'(rplen_ff) > room || 32'(rplen_ff) > RX_BUFFER_BYTES)
             ? room : BW'(rplen_ff);
   end

   logic [10:0] cur_len;
   assign cur_len = (remain_ff > 16'(segmax_ff)) ? segmax_ff : remain_ff[10:0];
   assign sts.more = (op_ff == OP_WRITE) && (remain_ff != 16'(cur_len)) &&
                     (nseg_ff != 7'(MaxResults - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_port_ff <= LISTEN_PORT_RESET;
         init_seq_ff <= INIT_SEQ_RESET;
         read_chunk_ff <= READ_CHUNK_RESET;
         write_seg_ff <= WRITE_SEG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LISTEN_PORT: listen_port_ff <= csr_wdata[15:0];
            CSR_INIT_SEQ:    init_seq_ff <= csr_wdata;
            CSR_READ_CHUNK:  read_chunk_ff <= csr_wdata[14:0];
            CSR_WRITE_SEG:   write_seg_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rtype_ff <= req_type; rmac_ff <= req_src_mac; rip_ff <= req_src_ip;
         rsport_ff <= req_src_port; rdport_ff <= req_dst_port;
         rseq_ff <= req_seq_in; rfl_ff <= req_flags_in;
         rplen_ff <= req_payload_len; rsel_ff <= req_conn_sel;
         rwlen_ff <= req_write_len;
      end
      if (cmd.search) begin
         match_ok_ff <= m_ok; match_ff <= m_i;
         free_ok_ff <= f_ok; free_ff <= f_i;
         poll_ok_ff <= p_ok; poll_ff <= p_i;
      end
   end

   // execute step: table update and result choice
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cursor_ff <= '0;
         op_ff <= OP_NONE;
      end else if (cmd.exec) begin
         op_ff <= OP_STATUS; sid_ff <= 3'd0; sval_ff <= '0; sfl_ff <= '0;
         release_ff <= 1'b0; ent_ff <= match_ff; nseg_ff <= '0;
         remain_ff <= rwlen_ff;
         segmax_ff <= (write_seg_ff < SEG_MIN) ? SEG_MIN :
                      (write_seg_ff > SEG_MAX) ? SEG_MAX : write_seg_ff;
         case (rtype_ff)
            REQ_SEGMENT: begin
               if (rdport_ff != listen_port_ff) begin
               end else if ((rfl_ff & FL_RST) != 8'd0) begin
                  if (match_ok_ff) begin
                     valid_ff[match_ff] <= 1'b0;
                     sid_ff <= 3'(match_ff) + 3'd1;
                  end
               end else if ((rfl_ff & FL_SYN) != 8'd0 && !match_ok_ff) begin
                  if (free_ok_ff) begin
                     valid_ff[free_ff] <= 1'b1;
                     mac_ff[free_ff] <= rmac_ff; ip_ff[free_ff] <= rip_ff;
                     port_ff[free_ff] <= rsport_ff;
                     rnext_ff[free_ff] <= rseq_ff + 32'd1;
                     snext_ff[free_ff] <= init_seq_ff;
                     buf_ff[free_ff] <= '0; closed_ff[free_ff] <= 1'b0;
                     ent_ff <= free_ff; op_ff <= OP_SEGMENT; sfl_ff <= FL_SYN;
                  end
               end else if (match_ok_ff) begin
                  sid_ff <= 3'(match_ff) + 3'd1;
                  if (rseq_ff == rnext_ff[match_ff]) begin
                     if (rplen_ff != 16'd0) begin
                        buf_ff[match_ff] <= buf_ff[match_ff] + take;
                     end
                     rnext_ff[match_ff] <= rnext_ff[match_ff] + 32'(rplen_ff) +
                                          32'(rfl_ff[0]);
                     if (rfl_ff[0]) closed_ff[match_ff] <= 1'b1;
                     sval_ff <= (rplen_ff != 16'd0) ? 16'(take) : 16'd0;
                  end
                  if (rplen_ff != 16'd0 || rfl_ff[0]) op_ff <= OP_SEGMENT;
               end
            end
            REQ_POLL: begin
               if (poll_ok_ff) begin
                  cursor_ff <= (32'(poll_ff) + 32'd1 >= TABLE_ENTRIES) ? '0 :
                               poll_ff + IW'(1);
                  sval_ff <= 16'(poll_ff) + 16'd1;
               end
            end
            REQ_READ: begin
               if (sel_ok) begin
                  sid_ff <= rsel_ff;
                  if (buf_ff[sel_i] > lim) begin
                     buf_ff[sel_i] <= buf_ff[sel_i] - lim; sval_ff <= 16'(lim);
                  end else begin
                     buf_ff[sel_i] <= '0; sval_ff <= 16'(buf_ff[sel_i]);
                  end
               end
            end
            REQ_CLOSE: begin
               if (sel_ok) begin
                  ent_ff <= sel_i; op_ff <= OP_SEGMENT; sfl_ff <= FL_FIN;
                  release_ff <= 1'b1;
               end
            end
            REQ_WRITE: begin
               if (sel_ok) begin
                  ent_ff <= sel_i; sid_ff <= rsel_ff;
                  if (rwlen_ff != 16'd0) begin
                     op_ff <= OP_WRITE; sfl_ff <= FL_PSH; sval_ff <= rwlen_ff;
                  end
               end
            end
            default: ;
         endcase
      end else begin
         if (cmd.emit && op_ff != OP_STATUS) begin
            snext_ff[ent_ff] <= snext_ff[ent_ff] +
               ((op_ff == OP_WRITE) ? 32'(cur_len) :
                ((sfl_ff & (FL_SYN | FL_FIN)) != 8'd0) ? 32'd1 : 32'd0);
            if (release_ff) valid_ff[ent_ff] <= 1'b0;
         end
         if (cmd.next_seg && op_ff == OP_WRITE) begin
            remain_ff <= remain_ff - 16'(cur_len);
            nseg_ff <= nseg_ff + 7'd1;
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_last <= !sts.more;
         rsp_value <= sval_ff;
         if (op_ff == OP_STATUS) begin
            rsp_out_kind <= 1'b0; rsp_conn_id <= sid_ff;
            rsp_peer_ip_out <= '0; rsp_peer_port_out <= '0; rsp_peer_mac_out <= '0;
            rsp_seq_out <= '0; rsp_ack_out <= '0; rsp_flags_out <= '0;
            rsp_seg_len <= '0;
         end else begin
            rsp_out_kind <= 1'b1; rsp_conn_id <= 3'(ent_ff) + 3'd1;
            rsp_peer_ip_out <= ip_ff[ent_ff]; rsp_peer_port_out <= port_ff[ent_ff];
            rsp_peer_mac_out <= mac_ff[ent_ff];
            rsp_seq_out <= snext_ff[ent_ff]; rsp_ack_out <= rnext_ff[ent_ff];
            rsp_flags_out <= sfl_ff | FL_ACK;
            rsp_seg_len <= (op_ff == OP_WRITE) ? cur_len : 11'd0;
         end
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/tcp_connection_table_engine_unit.sv @@
// top level of the tcp connection table engine
// usage: the req_ channel carries one word per segment or host command
// (poll, read, close, write); the rsp_ channel returns result words, the
// final one of each request flagged by rsp_last. csr_ writes set the listen
// port, initial send sequence, read chunk and write segment size; the user
// must write them only while no request is in flight; it is not enforced.
// steps: a request is taken in idle, then the controller runs a table
// search, a table update and the output register load before the first
// result is valid. a write yields one segment word per write segment size
// (the csr value clamped to 1024 to 1460 bytes), at most 64 words; each
// further word is loaded only once the receiver has taken the one before.
// no new request is taken until the final word of the current request has
// been taken by the receiver.
// reset: synchronous; clears the table valid bits, poll cursor and csr
// values to their defaults. when the receiver stalls, the result word holds
// in the output register and no new request is taken.
`default_nettype none
module tcp_connection_table_engine_unit #(
   parameter int TABLE_ENTRIES = tce_pkg::TableEntriesDefault,
   parameter int RX_BUFFER_BYTES = tce_pkg::RxBufferBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [47:0] req_src_mac,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [31:0] req_seq_in,
   input  wire logic [7:0]  req_flags_in,
   input  wire logic [15:0] req_payload_len,
   input  wire logic [2:0]  req_conn_sel,
   input  wire logic [15:0] req_write_len,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_out_kind,
   output logic [2:0]       rsp_conn_id,
   output logic [31:0]      rsp_peer_ip_out,
   output logic [15:0]      rsp_peer_port_out,
   output logic [47:0]      rsp_peer_mac_out,
   output logic [31:0]      rsp_seq_out,
   output logic [31:0]      rsp_ack_out,
   output logic [7:0]       rsp_flags_out,
   output logic [10:0]      rsp_seg_len,
   output logic [15:0]      rsp_value,
   output logic             rsp_last
);
   import tce_pkg::*;
   cmd_type cmd;
   sts_type sts;

   tce_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   tce_datapath #(
      .TABLE_ENTRIES(TABLE_ENTRIES), .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .csr_we, .csr_index, .csr_wdata,
      .req_type, .req_src_mac, .req_src_ip, .req_src_port, .req_dst_port,
      .req_seq_in, .req_flags_in, .req_payload_len, .req_conn_sel,
      .req_write_len, .rsp_out_kind, .rsp_conn_id, .rsp_peer_ip_out,
      .rsp_peer_port_out, .rsp_peer_mac_out, .rsp_seq_out, .rsp_ack_out,
      .rsp_flags_out, .rsp_seg_len, .rsp_value, .rsp_last
   );
endmodule
`default_nettype wire

@@ hw/rtl/tce_checker.sv @@
// port-level checker of the connection table engine and its bind
`default_nettype none
`include "tcp_connection_table_engine_unit_macros.svh"
module tce_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_out_kind,
   input wire logic [7:0]  rsp_flags_out,
   input wire logic [10:0] rsp_seg_len,
   input wire logic        rsp_last
);
   `TCE_ASSERT_IMPL(no_overlap, clock, reset, rsp_valid, !req_ready)
   `TCE_ASSERT_IMPL(ack_on_seg, clock, reset, rsp_valid && rsp_out_kind, rsp_flags_out[4])
   `TCE_ASSERT_IMPL(stat_no_len, clock, reset, rsp_valid && !rsp_out_kind, rsp_seg_len == 11'd0)
   `TCE_ASSERT_NEXT(accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `TCE_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_last))
endmodule

bind tcp_connection_table_engine_unit tce_checker u_tce_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_out_kind, .rsp_flags_out, .rsp_seg_len, .rsp_last
);
`default_nettype wire

@@ tb/tb_tcp_connection_table_engine_unit.sv @@
// testbench for the tcp connection table engine: predicted result words checked against the rsp_ channel
`default_nettype none
module tb_tcp_connection_table_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tce_pkg::*;

   localparam int NENT = 4;
   localparam int RXBUF = 16384;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  rtype;
      logic [47:0] mac;
      logic [31:0] ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] seq;
      logic [7:0]  flags;
      logic [15:0] plen;
      logic [2:0]  sel;
      logic [15:0] wlen;
   } req_word_type;

   localparam int REQ_BITS = $bits(req_word_type);

   typedef struct packed {
      logic        kind;
      logic [2:0]  id;
      logic [31:0] ip;
      logic [15:0] port;
      logic [47:0] mac;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  flags;
      logic [10:0] len;
      logic [15:0] value;
      logic        last;
   } rsp_word_type;

   logic clock, reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [31:0] csr_wdata;
   logic req_valid, req_ready;
   logic [2:0] req_type;
   logic [47:0] req_src_mac;
   logic [31:0] req_src_ip;
   logic [15:0] req_src_port, req_dst_port;
   logic [31:0] req_seq_in;
   logic [7:0] req_flags_in;
   logic [15:0] req_payload_len;
   logic [2:0] req_conn_sel;
   logic [15:0] req_write_len;
   logic rsp_valid, rsp_ready;
   logic rsp_out_kind;
   logic [2:0] rsp_conn_id;
   logic [31:0] rsp_peer_ip_out;
   logic [15:0] rsp_peer_port_out;
   logic [47:0] rsp_peer_mac_out;
   logic [31:0] rsp_seq_out, rsp_ack_out;
   logic [7:0] rsp_flags_out;
   logic [10:0] rsp_seg_len;
   logic [15:0] rsp_value;
   logic rsp_last;

   tcp_connection_table_engine_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_src_mac(req_src_mac), .req_src_ip(req_src_ip),
      .req_src_port(req_src_port), .req_dst_port(req_dst_port),
      .req_seq_in(req_seq_in), .req_flags_in(req_flags_in),
      .req_payload_len(req_payload_len), .req_conn_sel(req_conn_sel),
      .req_write_len(req_write_len),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_kind(rsp_out_kind), .rsp_conn_id(rsp_conn_id),
      .rsp_peer_ip_out(rsp_peer_ip_out), .rsp_peer_port_out(rsp_peer_port_out),
      .rsp_peer_mac_out(rsp_peer_mac_out), .rsp_seq_out(rsp_seq_out),
      .rsp_ack_out(rsp_ack_out), .rsp_flags_out(rsp_flags_out),
      .rsp_seg_len(rsp_seg_len), .rsp_value(rsp_value), .rsp_last(rsp_last)
   );

   // shadow copy of the connection table
   logic [15:0] cfg_port;
   logic [31:0] cfg_iss;
   logic [14:0] cfg_chunk;
   logic [10:0] cfg_wseg;
   logic        tbl_valid [NENT];
   logic [47:0] tbl_mac [NENT];
   logic [31:0] tbl_ip [NENT];
   logic [15:0] tbl_port [NENT];
   logic [31:0] tbl_rnxt [NENT];
   logic [31:0] tbl_snxt [NENT];
   logic [14:0] tbl_buf [NENT];
   int          cursor;

   rsp_word_type expected_words[$];
   int mismatches;
   int idle_send, idle_recv;
   int quiet_cycles;
   logic timed_out;

   // known peers for well-formed traffic
   logic [31:0] peer_ips [NENT];
   logic [15:0] peer_ports [NENT];
   logic [31:0] peer_seq [NENT];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_word_type status_word(int id, int val);
      rsp_word_type w;
      w = '0;
      w.id = id[2:0];
      w.value = val[15:0];
      return w;
   endfunction

   task automatic push_segment(int e, logic [7:0] fl, int len, int val);
      rsp_word_type w;
      w = '0;
      w.kind = 1'b1;
      w.id = 3'(e + 1);
      w.ip = tbl_ip[e];
      w.port = tbl_port[e];
      w.mac = tbl_mac[e];
      w.seq = tbl_snxt[e];
      w.ack = tbl_rnxt[e];
      w.flags = fl | FL_ACK;
      w.len = len[10:0];
      w.value = val[15:0];
      expected_words.push_back(w);
      tbl_snxt[e] = tbl_snxt[e] + 32'(len) + (((fl & (FL_SYN | FL_FIN)) != 0) ? 32'd1 : 32'd0);
   endtask

   function automatic int pick_entry(logic [2:0] sel);
      if (sel < 1 || sel > NENT) return -1;
      return tbl_valid[sel - 1] ? int'(sel) - 1 : -1;
   endfunction

   task automatic predict_segment(req_word_type r);
      int e, take, room;
      e = -1;
      if (r.dport != cfg_port) begin
         expected_words.push_back(status_word(0, 0));
         return;
      end
      for (int i = NENT - 1; i >= 0; i--)
         if (tbl_valid[i] && tbl_port[i] == r.sport && tbl_ip[i] == r.ip) e = i;
      if ((r.flags & FL_RST) != 0) begin
         if (e >= 0) tbl_valid[e] = 1'b0;
         expected_words.push_back(status_word(e + 1, 0));
         return;
      end
      if ((r.flags & FL_SYN) != 0 && e < 0) begin
         for (int i = NENT - 1; i >= 0; i--)
            if (!tbl_valid[i]) e = i;
         if (e < 0) begin
            expected_words.push_back(status_word(0, 0));
            return;
         end
         tbl_valid[e] = 1'b1;
         tbl_mac[e] = r.mac;
         tbl_ip[e] = r.ip;
         tbl_port[e] = r.sport;
         tbl_rnxt[e] = r.seq + 32'd1;
         tbl_snxt[e] = cfg_iss;
         tbl_buf[e] = '0;
         push_segment(e, FL_SYN, 0, 0);
         return;
      end
      if (e < 0) begin
         expected_words.push_back(status_word(0, 0));
         return;
      end
      if (r.seq == tbl_rnxt[e]) begin
         take = 0;
         if (r.plen != 0) begin
            room = RXBUF - int'(tbl_buf[e]);
            take = int'(r.plen) > room ? room : int'(r.plen);
            tbl_buf[e] = 15'(int'(tbl_buf[e]) + take);
            tbl_rnxt[e] = tbl_rnxt[e] + 32'(r.plen);
         end
         if ((r.flags & FL_FIN) != 0) tbl_rnxt[e] = tbl_rnxt[e] + 32'd1;
         if (r.plen != 0 || (r.flags & FL_FIN) != 0) push_segment(e, 8'h00, 0, take);
         else expected_words.push_back(status_word(e + 1, 0));
      end else if (r.plen != 0 || (r.flags & FL_FIN) != 0) begin
         push_segment(e, 8'h00, 0, 0);
      end else begin
         expected_words.push_back(status_word(e + 1, 0));
      end
   endtask

   task automatic predict_request(req_word_type r);
      int e, found, lim, d, total, off, segmax, len, n, i;
      if (r.rtype == REQ_SEGMENT) begin
         predict_segment(r);
      end else if (r.rtype == REQ_POLL) begin
         found = 0;
         for (int k = 0; k < NENT; k++) begin
            i = (cursor + k) % NENT;
            if (found == 0 && tbl_valid[i] && tbl_buf[i] != 0) begin
               cursor = (i + 1) % NENT;
               found = i + 1;
            end
         end
         expected_words.push_back(status_word(0, found));
      end else if (r.rtype == REQ_READ) begin
         e = pick_entry(r.sel);
         if (e < 0) begin
            expected_words.push_back(status_word(0, 0));
         end else begin
            lim = cfg_chunk == 0 ? 1 : int'(cfg_chunk);
            if (lim > RXBUF) lim = RXBUF;
            d = int'(tbl_buf[e]) > lim ? lim : int'(tbl_buf[e]);
            tbl_buf[e] = 15'(int'(tbl_buf[e]) - d);
            expected_words.push_back(status_word(e + 1, d));
         end
      end else if (r.rtype == REQ_CLOSE) begin
         e = pick_entry(r.sel);
         if (e < 0) begin
            expected_words.push_back(status_word(0, 0));
         end else begin
            push_segment(e, FL_FIN, 0, 0);
            tbl_valid[e] = 1'b0;
         end
      end else if (r.rtype == REQ_WRITE) begin
         e = pick_entry(r.sel);
         total = int'(r.wlen);
         if (e < 0) begin
            expected_words.push_back(status_word(0, 0));
         end else if (total == 0) begin
            expected_words.push_back(status_word(e + 1, 0));
         end else begin
            segmax = int'(cfg_wseg);
            if (segmax < 1024) segmax = 1024;
            if (segmax > 1460) segmax = 1460;
            off = 0;
            n = 0;
            while (off < total && n < 64) begin
               len = total - off > segmax ? segmax : total - off;
               push_segment(e, FL_PSH, len, total);
               off += len;
               n++;
            end
         end
      end else begin
         expected_words.push_back(status_word(0, 0));
      end
      expected_words[$].last = 1'b1;
   endtask

   task automatic send_word(req_word_type r);
      while ($urandom_range(99) < idle_send) @(posedge clock);
      req_valid <= 1'b1;
      req_type <= r.rtype;
      req_src_mac <= r.mac;
      req_src_ip <= r.ip;
      req_src_port <= r.sport;
      req_dst_port <= r.dport;
      req_seq_in <= r.seq;
      req_flags_in <= r.flags;
      req_payload_len <= r.plen;
      req_conn_sel <= r.sel;
      req_write_len <= r.wlen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(r);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_words.size() != 0 && !timed_out) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LISTEN_PORT: cfg_port = val[15:0];
         CSR_INIT_SEQ:    cfg_iss = val;
         CSR_READ_CHUNK:  cfg_chunk = val[14:0];
         default:         cfg_wseg = val[10:0];
      endcase
   endtask

   function automatic req_word_type blank_word(logic [2:0] t);
      req_word_type r;
      r = '0;
      r.rtype = t;
      r.dport = cfg_port;
      return r;
   endfunction

   function automatic req_word_type peer_segment(int p, logic [7:0] fl, int plen);
      req_word_type r;
      r = blank_word(REQ_SEGMENT);
      r.mac = 48'({$urandom, $urandom});
      r.ip = peer_ips[p];
      r.sport = peer_ports[p];
      r.seq = peer_seq[p];
      r.flags = fl;
      r.plen = plen[15:0];
      return r;
   endfunction

   function automatic req_word_type host_cmd(logic [2:0] t, int sel, int wlen);
      req_word_type r;
      r = blank_word(t);
      r.sel = sel[2:0];
      r.wlen = wlen[15:0];
      return r;
   endfunction

   task automatic open_peer(int p);
      peer_seq[p] = $urandom;
      send_word(peer_segment(p, FL_SYN, 0));
      peer_seq[p] = peer_seq[p] + 1;
   endtask

   task automatic test_directed();
      req_word_type r;
      for (int p = 0; p < NENT; p++) open_peer(p);
      open_peer(0);
      r = peer_segment(0, FL_SYN, 0);
      r.ip = 32'hFFFF_FFFF;
      r.sport = 16'hFFFF;
      r.mac = '1;
      send_word(r);
      send_word(peer_segment(1, FL_ACK | FL_PSH, 16'hFFFF));
      peer_seq[1] += 32'hFFFF;
      send_word(peer_segment(1, FL_ACK, 100));
      send_word(peer_segment(2, FL_ACK | FL_FIN, 0));
      send_word(peer_segment(2, FL_ACK, 0));
      send_word(peer_segment(2, FL_ACK, 5));
      r = peer_segment(3, 8'hFF, 0);
      r.dport = ~cfg_port;
      send_word(r);
      send_word(host_cmd(REQ_POLL, 0, 0));
      send_word(host_cmd(REQ_READ, 2, 0));
      send_word(host_cmd(REQ_READ, 0, 0));
      send_word(host_cmd(REQ_WRITE, 3, 16'hFFFF));
      send_word(host_cmd(REQ_WRITE, 3, 0));
      send_word(host_cmd(REQ_WRITE, 7, 10));
      send_word(host_cmd(REQ_CLOSE, 4, 0));
      send_word(host_cmd(REQ_CLOSE, 4, 0));
      send_word(peer_segment(3, FL_RST, 0));
      send_word(peer_segment(3, FL_RST, 0));
      send_word(host_cmd(3'd5, 0, 0));
      send_word(host_cmd(3'd7, 0, 0));
      send_word(host_cmd(3'd6, 0, 0));
   endtask

   task automatic test_random(int count);
      req_word_type r;
      int p, k;
      for (int n = 0; n < count; n++) begin
         p = $urandom_range(NENT - 1);
         k = $urandom_range(99);
         if (k < 10) begin
            if ($urandom_range(1)) peer_ips[p] = $urandom;
            open_peer(p);
         end else if (k < 40) begin
            r = peer_segment(p, 8'($urandom) & ~(FL_RST | FL_SYN),
                             $urandom_range(3) == 0 ? $urandom_range(65535)
                                                    : $urandom_range(1500));
            if ($urandom_range(5) == 0) r.seq = $urandom;
            send_word(r);
            if (r.seq == peer_seq[p])
               peer_seq[p] += 32'(r.plen) + ((r.flags & FL_FIN) != 0 ? 1 : 0);
         end else if (k < 50) begin
            send_word(host_cmd(REQ_POLL, 0, 0));
         end else if (k < 62) begin
            send_word(host_cmd(REQ_READ, $urandom_range(7), 0));
         end else if (k < 72) begin
            send_word(host_cmd(REQ_WRITE, $urandom_range(4),
                               $urandom_range(7) == 0 ? $urandom_range(65535)
                                                      : $urandom_range(4000)));
         end else if (k < 77) begin
            send_word(host_cmd(REQ_CLOSE, $urandom_range(7), 0));
         end else if (k < 80) begin
            send_word(peer_segment(p, FL_RST, 0));
         end else begin
            r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom});
            if ($urandom_range(1)) r.dport = cfg_port;
            send_word(r);
         end
      end
   endtask

   task automatic test_config_sweep();
      write_csr(CSR_LISTEN_PORT, 32'h0000_FFFF);
      write_csr(CSR_INIT_SEQ, 32'hFFFF_FFF0);
      write_csr(CSR_READ_CHUNK, 32'h0000_7FFF);
      write_csr(CSR_WRITE_SEG, 32'd0);
      test_random(40);
      write_csr(CSR_LISTEN_PORT, 32'd0);
      write_csr(CSR_INIT_SEQ, 32'd0);
      write_csr(CSR_READ_CHUNK, 32'd0);
      write_csr(CSR_WRITE_SEG, 32'h0000_07FF);
      test_random(40);
      write_csr(CSR_READ_CHUNK, 32'd1);
      write_csr(CSR_WRITE_SEG, 32'd1024);
      write_csr(CSR_INIT_SEQ, $urandom);
      write_csr(CSR_LISTEN_PORT, 32'($urandom_range(65535)));
      test_random(30);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_kind, rsp_conn_id, rsp_peer_ip_out, rsp_peer_port_out,
                   rsp_peer_mac_out, rsp_seq_out, rsp_ack_out, rsp_flags_out,
                   rsp_seg_len, rsp_value, rsp_last};
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_recv);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out <= 1'b1;
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      {req_type, req_src_mac, req_src_ip, req_src_port, req_dst_port, req_seq_in,
       req_flags_in, req_payload_len, req_conn_sel, req_write_len} = '0;
      rsp_ready = 1'b0;
      mismatches = 0;
      quiet_cycles = 0;
      timed_out = 1'b0;
      idle_send = 22;
      idle_recv = 58;
      cfg_port = LISTEN_PORT_RESET;
      cfg_iss = INIT_SEQ_RESET;
      cfg_chunk = READ_CHUNK_RESET;
      cfg_wseg = WRITE_SEG_RESET;
      cursor = 0;
      for (int i = 0; i < NENT; i++) begin
         tbl_valid[i] = 1'b0;
         peer_ips[i] = $urandom;
         peer_ports[i] = 16'($urandom);
         peer_seq[i] = $urandom;
      end
      peer_ports[3] = 16'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      idle_send = 58;
      idle_recv = 22;
      test_random(20);
      drain();
      test_random(10);
      idle_send = 0;
      idle_recv = 0;
      test_config_sweep();
      drain();
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
